// File: hdl/vmsn_pkg.sv
// ----------------------------------------------------------------------------
// Max-or-sum vector normalizer package
// Shared widths, state codes and control structs of the normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package vmsn_pkg;

    localparam int MAX_PEAKS = 16;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 17;
    localparam int IDX_W   = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int CNT_W   = $clog2(MAX_PEAKS + 1);
    localparam int SUM_W   = DATA_W + $clog2(MAX_PEAKS);
    localparam int REM_W   = SUM_W + 1;
    localparam int DIV_STEPS = FRAC_W;
    localparam int STEP_W  = $clog2(DIV_STEPS + 1);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_LOAD  = 3'd0;
    localparam logic [ST_W-1:0] ST_CLOSE = 3'd1;
    localparam logic [ST_W-1:0] ST_READ  = 3'd2;
    localparam logic [ST_W-1:0] ST_START = 3'd3;
    localparam logic [ST_W-1:0] ST_DIV   = 3'd4;
    localparam logic [ST_W-1:0] ST_EMIT  = 3'd5;

    typedef struct packed {
        logic load;
        logic close;
        logic rd_issue;
        logic div_start;
        logic div_step;
        logic out_load;
    } vmsn_cmd_t;

    typedef struct packed {
        logic div_done;
        logic last_peak;
        logic out_free;
    } vmsn_stat_t;

endpackage

`default_nettype wire

// File: hdl/vmsn_ctrl.sv
// ----------------------------------------------------------------------------
// Normalizer controller
// Sequences loading, group close, store reads, division and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module vmsn_ctrl
    import vmsn_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       group_end,
    output logic            in_stall,
    input  wire vmsn_stat_t stat,
    output vmsn_cmd_t       cmd
);

    logic [ST_W-1:0] state_reg;
    logic [ST_W-1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (group_end)
                    begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE:
            begin
                cmd.close  = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_START;
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = stat.last_peak ? ST_LOAD : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/vmsn_dp.sv
// ----------------------------------------------------------------------------
// Normalizer datapath
// Peak store, running maximum and sum, restoring divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vmsn_dp
    import vmsn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,
    input  wire logic [DATA_W-1:0] intensity,
    input  wire vmsn_cmd_t         cmd,
    output vmsn_stat_t             stat,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [FRAC_W-1:0]      fraction,
    output logic                   last_out
);

    logic [DATA_W-1:0] store_mem [MAX_PEAKS];
    logic [DATA_W-1:0] rd_data_reg;

    logic              mode_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [DATA_W-1:0] max_reg;
    logic [SUM_W-1:0]  sum_reg;

    logic [CNT_W-1:0]  emit_n_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [SUM_W-1:0]  div_reg;
    logic              div_zero_reg;

    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [FRAC_W-1:0] quo_reg;
    logic [STEP_W-1:0] step_reg;

    logic              out_valid_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic              last_reg;

    logic              not_full;
    logic              ge;
    logic [REM_W-1:0]  rem_sub;

    assign not_full = (count_reg < CNT_W'(MAX_PEAKS));
    assign ge       = (rem_reg >= {1'b0, div_reg});
    assign rem_sub  = ge ? (rem_reg - {1'b0, div_reg}) : rem_reg;
    assign rem_next = {rem_sub[REM_W-2:0], 1'b0};

    assign stat.div_done  = (step_reg == STEP_W'(DIV_STEPS));
    assign stat.last_peak = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == emit_n_reg);
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign fraction  = frac_reg;
    assign last_out  = last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load && not_full)
        begin
            store_mem[count_reg[IDX_W-1:0]] <= intensity;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= store_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            count_reg  <= '0;
            max_reg    <= '0;
            sum_reg    <= '0;
            emit_n_reg <= '0;
            rd_idx_reg <= '0;
            step_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (cmd.load && not_full)
            begin
                count_reg <= count_reg + CNT_W'(1);
                sum_reg   <= sum_reg + SUM_W'(intensity);
                if (intensity > max_reg)
                begin
                    max_reg <= intensity;
                end
            end
            if (cmd.close)
            begin
                emit_n_reg <= count_reg;
                rd_idx_reg <= '0;
                count_reg  <= '0;
                max_reg    <= '0;
                sum_reg    <= '0;
            end
            if (cmd.out_load)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
            if (cmd.div_start)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.close)
        begin
            div_reg      <= mode_reg ? sum_reg : SUM_W'(max_reg);
            div_zero_reg <= mode_reg ? (sum_reg == '0) : (max_reg == '0);
        end
        if (cmd.div_start)
        begin
            rem_reg <= REM_W'(rd_data_reg);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[FRAC_W-2:0], ge};
        end
        if (cmd.out_load)
        begin
            frac_reg <= div_zero_reg ? '0 : quo_reg;
            last_reg <= stat.last_peak;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: hdl/vector_max_or_sum_normalizer_unit.sv
// ----------------------------------------------------------------------------
// Max-or-sum vector normalizer
// Collects a group of peak intensities and emits each one divided by the group
// maximum or sum as an unsigned fraction with 16 fraction bits.
//
// Channel   Ports                                      Direction
// input     in_valid, in_stall, intensity, group_end   in (in_stall out)
// output    out_valid, out_stall, fraction, last_out   out (out_stall in)
// config    cfg_we, cfg_wdata                          in
//
// Items are taken whenever in_valid is high while a group is loading.
// After the closing item and a group close, each stored peak goes through one store
// read, a divider load, 17 restoring divider steps, a done check and the hand-off.
// Input stays stalled until the last peak of the group has been handed off.
// Reset clears control state and the mode register; the store needs no clearing.
// A stalled output holds its item; the block waits before loading the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_max_or_sum_normalizer_unit
    import vmsn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [DATA_W-1:0] intensity,
    input  wire logic              group_end,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [FRAC_W-1:0]      fraction,
    output logic                   last_out
);

    vmsn_cmd_t  cmd;
    vmsn_stat_t stat;

    vmsn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .group_end (group_end),
        .in_stall  (in_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    vmsn_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .intensity (intensity),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .fraction  (fraction),
        .last_out  (last_out)
    );

endmodule

`default_nettype wire

// File: hdl/vmsn_checker.sv
// ----------------------------------------------------------------------------
// Normalizer port checker
// Watches the top-level ports for output hold, range and group ordering.
// ----------------------------------------------------------------------------
`default_nettype none

module vmsn_checker
    import vmsn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic              group_end,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic [FRAC_W-1:0] fraction,
    input  wire logic              last_out
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(fraction) && $stable(last_out))
        else $error("Stalled output item changed.");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fraction <= FRAC_W'(65536))
        else $error("Fraction exceeds one.");

    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && group_end |=> in_stall)
        else $error("Input taken right after a group closed.");

    a_group_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_out |-> in_stall)
        else $error("Input taken while a group is still being emitted.");

endmodule

bind vector_max_or_sum_normalizer_unit vmsn_checker u_vmsn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .group_end (group_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .fraction  (fraction),
    .last_out  (last_out)
);

`default_nettype wire

// File: dv/vector_max_or_sum_normalizer_unit_tb.sv
// ----------------------------------------------------------------------------
// Max-or-sum vector normalizer testbench
// Sends groups of peak intensities under changing stall patterns and both
// normalization modes. Each fraction the block returns is checked against a
// scoreboard that keeps its own copy of the store, the maximum and the sum.
// ----------------------------------------------------------------------------
`default_nettype none

typedef enum logic {
    MODE_MAX = 1'b0,
    MODE_SUM = 1'b1
} norm_mode_t;

typedef enum int {
    KIND_ZERO,
    KIND_SMALL,
    KIND_HIGH,
    KIND_MIXED,
    KIND_WIDE
} peak_kind_t;

typedef struct packed {
    logic [vmsn_pkg::FRAC_W-1:0] frac;
    logic                        last;
} fraction_t;

class fraction_scoreboard;
    logic [vmsn_pkg::DATA_W-1:0] peaks [vmsn_pkg::MAX_PEAKS];
    int unsigned                 peak_total;
    logic [vmsn_pkg::DATA_W-1:0] group_max;
    logic [vmsn_pkg::SUM_W-1:0]  group_sum;
    bit                          overflowed;
    norm_mode_t                  mode;
    fraction_t                   expected_fractions[$];
    int unsigned                 mismatches;
    int unsigned                 checked;
    int unsigned                 groups;
    int unsigned                 overflow_groups;
    int unsigned                 zero_groups;

    function new();
        peak_total      = 0;
        group_max       = '0;
        group_sum       = '0;
        overflowed      = 0;
        mode            = MODE_MAX;
        mismatches      = 0;
        checked         = 0;
        groups          = 0;
        overflow_groups = 0;
        zero_groups     = 0;
    endfunction

    function void set_mode(norm_mode_t m);
        mode = m;
    endfunction

    function int unsigned pending();
        return expected_fractions.size();
    endfunction

    function void note_peak(logic [vmsn_pkg::DATA_W-1:0] v, logic closes);
        logic [vmsn_pkg::SUM_W-1:0] divisor;
        logic [63:0]                quotient;
        fraction_t                  item;
        if (peak_total < vmsn_pkg::MAX_PEAKS)
        begin
            peaks[peak_total] = v;
            peak_total++;
            if (v > group_max)
                group_max = v;
            group_sum += v;
        end
        else
            overflowed = 1;
        if (!closes)
            return;
        divisor = (mode == MODE_SUM) ? group_sum : vmsn_pkg::SUM_W'(group_max);
        if (divisor == '0)
            zero_groups++;
        if (overflowed)
            overflow_groups++;
        for (int k = 0; k < peak_total; k++)
        begin
            if (divisor == '0)
                quotient = '0;
            else
                quotient = (64'(peaks[k]) << 16) / 64'(divisor);
            if (quotient > 64'd65536)
                quotient = 64'd65536;
            item.frac = vmsn_pkg::FRAC_W'(quotient);
            item.last = (k == peak_total - 1);
            expected_fractions = {expected_fractions, item};
        end
        groups++;
        peak_total = 0;
        group_max  = '0;
        group_sum  = '0;
        overflowed = 0;
    endfunction

    function void check_fraction(logic [vmsn_pkg::FRAC_W-1:0] frac, logic last);
        fraction_t want;
        if (expected_fractions.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result: fraction %0d last %0b", frac, last);
            return;
        end
        want = expected_fractions.pop_front();
        checked++;
        if (frac !== want.frac || last !== want.last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch: expected fraction %0d last %0b, got fraction %0d last %0b",
                         want.frac, want.last, frac, last);
        end
    endfunction
endclass

module vector_max_or_sum_normalizer_unit_tb;
    import vmsn_pkg::*;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic              cfg_wdata = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [DATA_W-1:0] intensity = '0;
    logic              group_end = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [FRAC_W-1:0] fraction;
    logic              last_out;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    fraction_scoreboard sb = new();

    vector_max_or_sum_normalizer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .intensity (intensity),
        .group_end (group_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .fraction  (fraction),
        .last_out  (last_out)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (rst_n && out_valid && !out_stall)
            sb.check_fraction(fraction, last_out);
    end

    initial
    begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_peak(input logic [DATA_W-1:0] v, input logic closes);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        intensity <= v;
        group_end <= closes;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_peak(v, closes);
    endtask

    task automatic wait_for_fractions();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_norm_mode(input norm_mode_t m);
        wait_for_fractions();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_mode(m);
    endtask

    function automatic logic [DATA_W-1:0] pick_intensity(peak_kind_t kind);
        case (kind)
            KIND_ZERO:  return '0;
            KIND_SMALL: return DATA_W'($urandom_range(15));
            KIND_HIGH:  return {16'hFFFF, 16'($urandom)};
            KIND_MIXED:
                case ($urandom_range(4))
                    0:       return '0;
                    1:       return '1;
                    2:       return DATA_W'($urandom_range(15));
                    3:       return DATA_W'(1) << $urandom_range(DATA_W - 1);
                    default: return $urandom;
                endcase
            default:    return $urandom;
        endcase
    endfunction

    task automatic send_random_groups(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        peak_kind_t  kind;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                len = 1;
            else if (pick < 20)
                len = $urandom_range(MAX_PEAKS + 4, MAX_PEAKS + 1);
            else
                len = $urandom_range(MAX_PEAKS, 2);
            pick = $urandom_range(9);
            case (pick)
                0:       kind = KIND_ZERO;
                1:       kind = KIND_SMALL;
                2:       kind = KIND_HIGH;
                3, 4:    kind = KIND_MIXED;
                default: kind = KIND_WIDE;
            endcase
            for (int i = 0; i < len; i++)
                send_peak(pick_intensity(kind), i == len - 1);
            sent += len;
        end
    endtask

    initial
    begin
        int unsigned send_pct [3];
        int unsigned recv_pct [3];
        int unsigned waited;
        send_pct = '{6, 87, 0};
        recv_pct = '{87, 6, 0};
        send_idle_pct = send_pct[0];
        recv_idle_pct = recv_pct[0];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_norm_mode(MODE_MAX);
        send_peak('0, 1'b1);
        send_peak('1, 1'b0);
        send_peak(32'd1, 1'b0);
        send_peak(32'h8000_0000, 1'b0);
        send_peak(32'h7FFF_FFFF, 1'b1);

        // The last item of this group arrives with the store full and is dropped.
        write_norm_mode(MODE_SUM);
        for (int i = 0; i < MAX_PEAKS; i++)
            send_peak((i == 0) ? '0 : (32'hFFFF_FFFF >> i), 1'b0);
        send_peak('1, 1'b1);
        send_peak('0, 1'b1);
        send_peak('1, 1'b1);

        for (int p = 0; p < 3; p++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                write_norm_mode(((p + h) % 2 == 0) ? MODE_SUM : MODE_MAX);
                send_idle_pct = send_pct[p];
                recv_idle_pct = recv_pct[p];
                send_random_groups(55);
            end
        end

        in_valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);

        $display("Checked %0d fractions from %0d groups, both modes, three stall patterns.",
                 sb.checked, sb.groups);
        $display("%0d groups overflowed the store, %0d had a zero divisor, %0d results missing.",
                 sb.overflow_groups, sb.zero_groups, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
